// ----- design/mqtt_pr_pkg.sv -----
// shared types and constants for the mqtt packet responder
// no dependencies; imported by mqtt_packet_responder_core
package mqtt_pr_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_TX     = 2'd0;
    localparam kind_t KIND_DISC   = 2'd1;
    localparam kind_t KIND_BADLEN = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    localparam int unsigned MaxResults = 4;

    // control packet types from the fixed header
    localparam logic [3:0] TYPE_CONNECT    = 4'd1;
    localparam logic [3:0] TYPE_PUBLISH    = 4'd3;
    localparam logic [3:0] TYPE_PINGREQ    = 4'd12;
    localparam logic [3:0] TYPE_DISCONNECT = 4'd14;

    // response bytes
    localparam logic [7:0] BYTE_CONNACK  = 8'h20;
    localparam logic [7:0] BYTE_PUBACK   = 8'h40;
    localparam logic [7:0] BYTE_PINGRESP = 8'hD0;
    localparam logic [7:0] BYTE_LEN_TWO  = 8'h02;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

endpackage

// ----- design/mqtt_packet_responder_core.sv -----
// mqtt packet responder: byte-serial parser with response generation
// path: results of an item are loaded into the run buffer at its accepting edge and
//   pass one at a time through the output register to m_; m_tready can hold them
// throughput: one item per cycle when it causes no result; an item with n results (1..4)
//   is accepted only once the single output register has drained the run buffer
// reset: aresetn synchronous active low, parser to awaiting header, no pending items
module mqtt_packet_responder_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] cmd (1 = new connection)
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] tx_byte
    output mqtt_pr_pkg::kind_t   m_tuser,   // [1:0] kind
    output logic                 m_tlast    // last_of_run
);
    import mqtt_pr_pkg::*;

    // parser phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_CLOSED = 2'd3;

    // parser state
    logic [1:0]  phase_reg,      phase_next;
    logic [7:0]  header_reg,     header_next;
    logic [27:0] length_reg,     length_next;
    logic [2:0]  len_seen_reg,   len_seen_next;
    logic [27:0] body_cnt_reg,   body_cnt_next;
    logic [15:0] topic_len_reg,  topic_len_next;
    logic [15:0] pkt_ident_reg,  pkt_ident_next;

    // run buffer: results of the last accepted item, drained one per cycle while the output register is free
    result_t     rb_reg [MaxResults];
    logic [2:0]  rb_cnt_reg;
    logic [1:0]  rb_idx_reg;

    // output register
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        out_last_reg;

    // results computed for the item at the input
    result_t     res [MaxResults];
    logic [2:0]  res_cnt;

    logic        in_fire;
    logic        pop;

    // packet completion operands
    logic        done_fire;
    logic [27:0] done_len;
    logic [15:0] done_topic;
    logic [15:0] done_ident;
    logic [1:0]  qos;
    logic [17:0] pub_need;
    logic        pub_ok;

    // length decode
    logic [4:0]  len_shift;
    logic [27:0] len_sum;

    // body capture
    logic [16:0] id_pos;
    logic [17:0] id_pos_lo;

    // output register frees up when empty or being taken
    assign pop      = (rb_cnt_reg != 3'd0) && (!out_valid_reg || m_tready);
    // accept when the buffer is empty or while its last result leaves this cycle
    assign s_tready = (rb_cnt_reg == 3'd0) || ((rb_cnt_reg == 3'd1) && pop);
    assign in_fire  = s_tvalid && s_tready;

    assign qos = header_reg[2:1];

    // 7 bits per length byte, least significant group first
    always_comb begin
        case (len_seen_reg[1:0])
            2'd0:    len_shift = 5'd0;
            2'd1:    len_shift = 5'd7;
            2'd2:    len_shift = 5'd14;
            default: len_shift = 5'd21;
        endcase
    end

    assign len_sum   = length_reg + (28'(s_tdata[6:0]) << len_shift);
    assign id_pos    = 17'd2 + 17'(topic_len_reg);
    assign id_pos_lo = 18'(id_pos) + 18'd1;

    // publish needs the topic length field, the topic and, with qos, the packet id
    assign pub_need = 18'd2 + 18'(done_topic) + ((qos != 2'd0) ? 18'd2 : 18'd0);
    assign pub_ok   = (done_len >= 28'd2) && (done_len >= 28'(pub_need)) && (qos == 2'd1);

    always_comb begin
        phase_next     = phase_reg;
        header_next    = header_reg;
        length_next    = length_reg;
        len_seen_next  = len_seen_reg;
        body_cnt_next  = body_cnt_reg;
        topic_len_next = topic_len_reg;
        pkt_ident_next = pkt_ident_reg;
        done_fire      = 1'b0;
        done_len       = length_reg;
        done_topic     = topic_len_reg;
        done_ident     = pkt_ident_reg;
        res_cnt        = 3'd0;
        for (int i = 0; i < MaxResults; i++) begin
            res[i] = '{kind: KIND_TX, data: BYTE_ZERO};
        end

        if (s_tuser) begin
            // new connection: everything back to reset values
            phase_next     = PH_HEADER;
            header_next    = 8'd0;
            length_next    = 28'd0;
            len_seen_next  = 3'd0;
            body_cnt_next  = 28'd0;
            topic_len_next = 16'd0;
            pkt_ident_next = 16'd0;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    header_next    = s_tdata;
                    length_next    = 28'd0;
                    len_seen_next  = 3'd0;
                    body_cnt_next  = 28'd0;
                    topic_len_next = 16'd0;
                    pkt_ident_next = 16'd0;
                    phase_next     = PH_LENGTH;
                end
                PH_LENGTH: begin
                    length_next   = len_sum;
                    len_seen_next = len_seen_reg + 3'd1;
                    if (!s_tdata[7]) begin
                        if (len_sum == 28'd0) begin
                            // empty body completes the packet at once
                            done_fire = 1'b1;
                            done_len  = len_sum;
                        end else begin
                            body_cnt_next = 28'd0;
                            phase_next    = PH_BODY;
                        end
                    end else if (len_seen_reg == 3'd3) begin
                        // continuation on the fourth length byte
                        phase_next = PH_CLOSED;
                        res[0]     = '{kind: KIND_BADLEN, data: BYTE_ZERO};
                        res_cnt    = 3'd1;
                    end
                end
                PH_BODY: begin
                    if (header_reg[7:4] == TYPE_PUBLISH) begin
                        if (body_cnt_reg == 28'd0) begin
                            topic_len_next = {s_tdata, topic_len_reg[7:0]};
                        end else if (body_cnt_reg == 28'd1) begin
                            topic_len_next = {topic_len_reg[15:8], s_tdata};
                        end else if (body_cnt_reg == 28'(id_pos)) begin
                            pkt_ident_next = {s_tdata, pkt_ident_reg[7:0]};
                        end else if (body_cnt_reg == 28'(id_pos_lo)) begin
                            pkt_ident_next = {pkt_ident_reg[15:8], s_tdata};
                        end
                    end
                    body_cnt_next = body_cnt_reg + 28'd1;
                    if (body_cnt_next == length_reg) begin
                        done_fire  = 1'b1;
                        done_len   = length_reg;
                        done_topic = topic_len_next;
                        done_ident = pkt_ident_next;
                    end
                end
                default: begin
                    // closed: bytes ignored until a new connection
                end
            endcase

            if (done_fire) begin
                phase_next = PH_HEADER;
                case (header_reg[7:4])
                    TYPE_CONNECT: begin
                        res[0]  = '{kind: KIND_TX, data: BYTE_CONNACK};
                        res[1]  = '{kind: KIND_TX, data: BYTE_LEN_TWO};
                        res[2]  = '{kind: KIND_TX, data: BYTE_ZERO};
                        res[3]  = '{kind: KIND_TX, data: BYTE_ZERO};
                        res_cnt = 3'd4;
                    end
                    TYPE_PUBLISH: begin
                        if (pub_ok) begin
                            res[0]  = '{kind: KIND_TX, data: BYTE_PUBACK};
                            res[1]  = '{kind: KIND_TX, data: BYTE_LEN_TWO};
                            res[2]  = '{kind: KIND_TX, data: done_ident[15:8]};
                            res[3]  = '{kind: KIND_TX, data: done_ident[7:0]};
                            res_cnt = 3'd4;
                        end
                    end
                    TYPE_PINGREQ: begin
                        res[0]  = '{kind: KIND_TX, data: BYTE_PINGRESP};
                        res[1]  = '{kind: KIND_TX, data: BYTE_ZERO};
                        res_cnt = 3'd2;
                    end
                    TYPE_DISCONNECT: begin
                        phase_next = PH_CLOSED;
                        res[0]     = '{kind: KIND_DISC, data: BYTE_ZERO};
                        res_cnt    = 3'd1;
                    end
                    default: begin
                        // other packet types consumed without answer
                    end
                endcase
            end
        end
    end

    // parser state and run buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            header_reg    <= 8'd0;
            length_reg    <= 28'd0;
            len_seen_reg  <= 3'd0;
            body_cnt_reg  <= 28'd0;
            topic_len_reg <= 16'd0;
            pkt_ident_reg <= 16'd0;
            rb_cnt_reg    <= 3'd0;
            rb_idx_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                phase_reg     <= phase_next;
                header_reg    <= header_next;
                length_reg    <= length_next;
                len_seen_reg  <= len_seen_next;
                body_cnt_reg  <= body_cnt_next;
                topic_len_reg <= topic_len_next;
                pkt_ident_reg <= pkt_ident_next;
            end
            // a push only happens when the buffer is empty or emptying
            if (in_fire) begin
                rb_cnt_reg <= res_cnt;
                rb_idx_reg <= 2'd0;
            end else if (pop) begin
                rb_cnt_reg <= rb_cnt_reg - 3'd1;
                rb_idx_reg <= rb_idx_reg + 2'd1;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < MaxResults; i++) begin
                rb_reg[i] <= res[i];
            end
        end
        if (pop) begin
            out_res_reg  <= rb_reg[rb_idx_reg];
            out_last_reg <= (rb_cnt_reg == 3'd1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.data;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // run buffer never holds more than one run
    a_rb_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rb_cnt_reg <= 3'(MaxResults))
        else $error("run buffer count out of range");

    // a closing result is always alone in its run and carries no byte
    a_close_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != KIND_TX)) |-> (m_tlast && (m_tdata == BYTE_ZERO)))
        else $error("closing result not a single zero item");

    // bytes on a closed connection cause no result and keep it closed
    a_closed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_tuser && (phase_reg == PH_CLOSED))
        |=> ((rb_cnt_reg == 3'd0) && (phase_reg == PH_CLOSED)))
        else $error("closed connection produced a result");

    // new connection returns the parser to the header phase with nothing pending
    a_new_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser) |=> ((phase_reg == PH_HEADER) && (rb_cnt_reg == 3'd0)))
        else $error("new connection did not reset the parser");

    // length decode never gets past four bytes without closing
    a_len_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENGTH) |-> (len_seen_reg <= 3'd3))
        else $error("length byte count overrun");
`endif

endmodule
